// File: design/csi_magnitude_capture_buffer_top_macros.svh
// Assertion macros for the CSI magnitude capture buffer checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef CSI_MAGNITUDE_CAPTURE_BUFFER_TOP_MACROS_SVH
`define CSI_MAGNITUDE_CAPTURE_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSIMCB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSIMCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/csimcb_pkg.sv
// Shared types and constants of the CSI magnitude capture buffer.
// No dependencies; imported by csimcb_ctrl, csimcb_dp, the top level and the checker.
package csimcb_pkg;

    localparam int CSIMCB_MAX_PACKETS = 1024;
    localparam int CSIMCB_SUBCARRIERS = 64;

    localparam logic [10:0] BUFFER_PACKETS_RST = 11'd1024;
    localparam logic [5:0]  GUARD_LOW_RST      = 6'd11;
    localparam logic [5:0]  GUARD_HIGH_RST     = 6'd52;
    localparam logic [5:0]  DC_INDEX_RST       = 6'd32;
    localparam logic [7:0]  MAG_MAX            = 8'd255;

    typedef enum logic [2:0] {
        REQ_OPEN_WRITE   = 3'd0,
        REQ_OPEN_READ    = 3'd1,
        REQ_CLOSE        = 3'd2,
        REQ_DISCARD      = 3'd3,
        REQ_WRITE_SAMPLE = 3'd4,
        REQ_READ_BYTE    = 3'd5
    } req_code_t;

    typedef enum logic [3:0] {
        ST_DONE         = 4'd0,
        ST_OPEN_FAILED  = 4'd1,
        ST_SAMPLE_TAKEN = 4'd2,
        ST_STORED       = 4'd3,
        ST_REJECTED     = 4'd4,
        ST_FULL         = 4'd5,
        ST_NOT_OPEN     = 4'd6,
        ST_READ_OK      = 4'd7,
        ST_READ_EMPTY   = 4'd8
    } status_code_t;

    typedef enum logic [1:0] {
        CFG_BUFFER_PACKETS = 2'd0,
        CFG_GUARD_LOW      = 2'd1,
        CFG_GUARD_HIGH     = 2'd2,
        CFG_DC_INDEX       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic signed [7:0] q_sample;
        logic signed [7:0] i_sample;
        logic              last_sample;
        logic [9:0]        start_packet;
        logic [10:0]       window_packets;
        logic [15:0]       byte_offset;
    } csimcb_req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  read_byte;
        logic        is_full_flag;
        logic [10:0] stored_packets;
    } csimcb_rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic sqrt_start;
        logic commit;
        logic rd_prep;
        logic rd_check;
        logic rd_finish;
    } csimcb_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_write;
        logic is_read;
        logic sample_ok;
        logic sqrt_done;
    } csimcb_sts_t;

endpackage

// File: design/csimcb_isqrt.sv
// Iterative integer square root of a 16-bit radicand, two radicand bits per cycle.
// Depends on nothing but the clock and reset.
module csimcb_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] radicand,
    output logic        done,
    output logic [15:0] root
);

    localparam int STEPS = 8;

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [2:0]  k_reg, k_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;

    logic [15:0] bit_val;
    logic [16:0] trial;
    logic        take;

    assign bit_val = 16'(1) << {k_reg, 1'b0};
    assign trial   = {1'b0, root_reg} + {1'b0, bit_val};
    assign take    = {1'b0, rem_reg} >= trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            rem_next  = radicand;
            root_next = '0;
            k_next    = 3'(STEPS - 1);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (take)
            begin
                rem_next  = rem_reg - trial[15:0];
                root_next = (root_reg >> 1) + bit_val;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            k_next = k_reg - 3'd1;
            if (k_reg == 3'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: design/csimcb_ctrl.sv
// Sequencing state machine of the CSI magnitude capture buffer.
// Depends on csimcb_pkg; drives csimcb_dp through command and status structs.
module csimcb_ctrl
    import csimcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  csimcb_sts_t sts,
    output csimcb_cmd_t cmd,
    output logic        busy,
    output logic        done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SQRT,
        S_RD_CHECK,
        S_RD_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    busy_next  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.is_write && sts.sample_ok)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
                else if (sts.is_read)
                begin
                    cmd.rd_prep = 1'b1;
                    state_next  = S_RD_CHECK;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SQRT:
            begin
                // hold until the root is out
                if (sts.sqrt_done)
                begin
                    cmd.commit = 1'b1;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_CHECK:
            begin
                cmd.rd_check = 1'b1;
                state_next   = S_RD_DONE;
            end
            S_RD_DONE:
            begin
                cmd.rd_finish = 1'b1;
                busy_next     = 1'b0;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: design/csimcb_dp.sv
// Datapath: configuration, buffer state, magnitude store and read window logic.
// Depends on csimcb_pkg and csimcb_isqrt; commanded by csimcb_ctrl.
module csimcb_dp
    import csimcb_pkg::*;
#(
    parameter int MAX_PACKETS = CSIMCB_MAX_PACKETS,
    parameter int SUBCARRIERS = CSIMCB_SUBCARRIERS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  csimcb_req_t req,
    input  csimcb_cmd_t cmd,
    output csimcb_sts_t sts,
    output csimcb_rsp_t rsp
);

    localparam int CNT_W = $clog2(MAX_PACKETS + 1);
    localparam int IDX_W = $clog2(SUBCARRIERS + 1);
    localparam int PW    = (CNT_W > 11) ? CNT_W : 11;
    localparam int BW    = (((PW + IDX_W) > 16) ? (PW + IDX_W) : 16) + 1;
    localparam int DEPTH = MAX_PACKETS * SUBCARRIERS;
    localparam int AW    = $clog2(DEPTH);
    localparam int GW    = (IDX_W > 6) ? IDX_W : 6;

    // configuration
    logic [10:0]      bufpk_reg, bufpk_next;
    logic [5:0]       glow_reg, glow_next;
    logic [5:0]       ghigh_reg, ghigh_next;
    logic [5:0]       dc_reg, dc_next;

    // buffer state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] sidx_reg, sidx_next;
    logic             lerr_reg, lerr_next;
    logic             open_reg, open_next;
    logic             hasbuf_reg, hasbuf_next;

    // read window
    logic             prehit_reg, prehit_next;
    logic             hit_reg, hit_next;

    // result
    logic [3:0]       status_reg, status_next;
    logic [7:0]       rbyte_reg, rbyte_next;

    // transaction payload
    csimcb_req_t      item_reg;
    logic [15:0]      sq_reg;
    logic [PW-1:0]    wlen_reg;
    logic [BW-1:0]    base_reg;
    logic [7:0]       rdata_reg;

    logic [7:0]       mem [DEPTH];

    logic signed [15:0] ii_prod;
    logic signed [15:0] qq_prod;
    logic [15:0]        sq_sum;

    logic [PW-1:0]    count_ext;
    logic [PW-1:0]    bufpk_ext;
    logic [PW-1:0]    cap;
    logic             full;
    logic             open_bad;

    logic [PW-1:0]    start_ext;
    logic [PW-1:0]    win_ext;
    logic [PW-1:0]    avail;
    logic [PW-1:0]    wlen;
    logic             prehit;
    logic [BW-1:0]    base;
    logic [BW-1:0]    wbytes;
    logic [BW-1:0]    off_ext;
    logic [BW-1:0]    addr_full;
    logic             hit;

    logic [GW-1:0]    sc_ext;
    logic             in_band;
    logic             sc_room;
    logic             lerr_eff;
    logic             pkt_ok;
    logic [15:0]      root;
    logic             sqrt_done;
    logic [7:0]       mag;
    logic [7:0]       wr_val;
    logic [BW-1:0]    wr_addr_full;
    logic             mem_we;

    csimcb_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    assign ii_prod = req.i_sample * req.i_sample;
    assign qq_prod = req.q_sample * req.q_sample;
    assign sq_sum  = 16'($unsigned(ii_prod)) + 16'($unsigned(qq_prod));

    // capacity is min(buffer_packets, MAX_PACKETS)
    assign count_ext = PW'(count_reg);
    assign bufpk_ext = PW'(bufpk_reg);
    assign cap       = (bufpk_ext < PW'(MAX_PACKETS)) ? bufpk_ext : PW'(MAX_PACKETS);
    assign full      = count_ext >= cap;
    assign open_bad  = (bufpk_reg == 11'd0) || (bufpk_ext > PW'(MAX_PACKETS));

    // read window, first step: clamp the length and form the packet base
    assign start_ext = PW'(item_reg.start_packet);
    assign win_ext   = PW'(item_reg.window_packets);
    assign prehit    = hasbuf_reg && (start_ext < count_ext);
    assign avail     = count_ext - start_ext;
    assign wlen      = (win_ext < avail) ? win_ext : avail;
    assign base      = BW'(item_reg.start_packet) * BW'(SUBCARRIERS);

    // read window, second step: bound the offset and form the byte address
    assign wbytes    = BW'(wlen_reg) * BW'(SUBCARRIERS);
    assign off_ext   = BW'(item_reg.byte_offset);
    assign addr_full = base_reg + off_ext;
    assign hit       = prehit_reg && (off_ext < wbytes) && (addr_full < BW'(DEPTH));

    // sample write
    assign sc_ext   = GW'(sidx_reg);
    assign in_band  = !((sc_ext < GW'(glow_reg)) || (sc_ext > GW'(ghigh_reg))
                        || (sc_ext == GW'(dc_reg)));
    assign sc_room  = sidx_reg < IDX_W'(SUBCARRIERS);
    assign lerr_eff = lerr_reg || !sc_room;
    assign pkt_ok   = !lerr_eff && (sidx_reg == IDX_W'(SUBCARRIERS - 1));
    assign mag      = (root > 16'(MAG_MAX)) ? MAG_MAX : root[7:0];
    assign wr_val   = in_band ? mag : 8'd0;
    assign wr_addr_full = BW'(count_reg) * BW'(SUBCARRIERS) + BW'(sidx_reg);
    assign mem_we   = cmd.commit && sc_room;

    always_comb
    begin
        bufpk_next  = bufpk_reg;
        glow_next   = glow_reg;
        ghigh_next  = ghigh_reg;
        dc_next     = dc_reg;
        count_next  = count_reg;
        sidx_next   = sidx_reg;
        lerr_next   = lerr_reg;
        open_next   = open_reg;
        hasbuf_next = hasbuf_reg;
        prehit_next = prehit_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        rbyte_next  = rbyte_reg;

        if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_BUFFER_PACKETS: bufpk_next = cfg_data;
                CFG_GUARD_LOW:      glow_next  = cfg_data[5:0];
                CFG_GUARD_HIGH:     ghigh_next = cfg_data[5:0];
                CFG_DC_INDEX:       dc_next    = cfg_data[5:0];
                default:            ;
            endcase
        end

        if (cmd.exec)
        begin
            status_next = ST_DONE;
            rbyte_next  = 8'd0;
            unique case (item_reg.req_type)
                REQ_OPEN_WRITE:
                begin
                    sidx_next = '0;
                    lerr_next = 1'b0;
                    if (open_bad)
                    begin
                        status_next = ST_OPEN_FAILED;
                    end
                    else
                    begin
                        hasbuf_next = 1'b1;
                        open_next   = 1'b1;
                        count_next  = '0;
                    end
                end
                REQ_OPEN_READ:
                begin
                    sidx_next = '0;
                    lerr_next = 1'b0;
                    if (!hasbuf_reg)
                        status_next = ST_OPEN_FAILED;
                    else
                        open_next = 1'b1;
                end
                REQ_CLOSE:
                begin
                    sidx_next = '0;
                    lerr_next = 1'b0;
                    open_next = 1'b0;
                end
                REQ_DISCARD:
                begin
                    sidx_next   = '0;
                    lerr_next   = 1'b0;
                    hasbuf_next = 1'b0;
                    count_next  = '0;
                end
                REQ_WRITE_SAMPLE:
                begin
                    status_next = full ? ST_FULL : ST_NOT_OPEN;
                end
                REQ_READ_BYTE:
                begin
                    status_next = ST_READ_EMPTY;
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end

        if (cmd.commit)
        begin
            rbyte_next = 8'd0;
            if (sc_room)
                sidx_next = sidx_reg + IDX_W'(1);
            lerr_next = lerr_eff;
            if (item_reg.last_sample)
            begin
                if (pkt_ok)
                begin
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_STORED;
                end
                else
                begin
                    status_next = ST_REJECTED;
                end
                sidx_next = '0;
                lerr_next = 1'b0;
            end
            else
            begin
                status_next = ST_SAMPLE_TAKEN;
            end
        end

        if (cmd.rd_prep)
            prehit_next = prehit;

        if (cmd.rd_check)
            hit_next = hit;

        if (cmd.rd_finish)
        begin
            status_next = hit_reg ? ST_READ_OK : ST_READ_EMPTY;
            rbyte_next  = hit_reg ? rdata_reg : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bufpk_reg  <= BUFFER_PACKETS_RST;
            glow_reg   <= GUARD_LOW_RST;
            ghigh_reg  <= GUARD_HIGH_RST;
            dc_reg     <= DC_INDEX_RST;
            count_reg  <= '0;
            sidx_reg   <= '0;
            lerr_reg   <= 1'b0;
            open_reg   <= 1'b0;
            hasbuf_reg <= 1'b0;
            prehit_reg <= 1'b0;
            hit_reg    <= 1'b0;
            status_reg <= ST_DONE;
            rbyte_reg  <= 8'd0;
        end
        else
        begin
            bufpk_reg  <= bufpk_next;
            glow_reg   <= glow_next;
            ghigh_reg  <= ghigh_next;
            dc_reg     <= dc_next;
            count_reg  <= count_next;
            sidx_reg   <= sidx_next;
            lerr_reg   <= lerr_next;
            open_reg   <= open_next;
            hasbuf_reg <= hasbuf_next;
            prehit_reg <= prehit_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
            rbyte_reg  <= rbyte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
            sq_reg   <= sq_sum;
        end
        if (cmd.rd_prep)
        begin
            wlen_reg <= wlen;
            base_reg <= base;
        end
    end

    // magnitude store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr_full[AW-1:0]] <= wr_val;
        if (cmd.rd_check)
            rdata_reg <= mem[addr_full[AW-1:0]];
    end

    assign sts.is_write  = item_reg.req_type == REQ_WRITE_SAMPLE;
    assign sts.is_read   = item_reg.req_type == REQ_READ_BYTE;
    assign sts.sample_ok = !full && hasbuf_reg && open_reg;
    assign sts.sqrt_done = sqrt_done;

    assign rsp.status         = status_reg;
    assign rsp.read_byte      = rbyte_reg;
    assign rsp.is_full_flag   = full;
    assign rsp.stored_packets = 11'(count_reg);

endmodule

// File: design/csi_magnitude_capture_buffer_top.sv
// Top level of the CSI magnitude capture buffer: controller plus datapath.
// Depends on csimcb_pkg, csimcb_ctrl, csimcb_dp and csimcb_isqrt.
//
// A transaction is taken at a rising edge with start high and busy low; its one
// result appears on rsp for exactly one cycle with done high, and cannot be held
// off by the receiver, so capture it on that cycle. busy drops in the same cycle
// as done, so the next transaction may be issued while the result is shown.
// Path from accept to done, per request: open, close, discard, unknown codes
// and refused samples end in the dispatch state; a read byte passes window clamp,
// address bound plus store read, and result; an accepted sample passes the I/Q
// squaring, then the iterative square root, which retires two radicand bits a
// cycle until the root is out, and finally the store write. The store holds
// MAX_PACKETS*SUBCARRIERS bytes with no reset; only bytes of committed packets
// are ever returned. Configuration writes land at once and must be issued only
// while no transaction is outstanding.
module csi_magnitude_capture_buffer_top
    import csimcb_pkg::*;
#(
    parameter int MAX_PACKETS = CSIMCB_MAX_PACKETS,
    parameter int SUBCARRIERS = CSIMCB_SUBCARRIERS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  csimcb_req_t req,
    output logic        done,
    output csimcb_rsp_t rsp,
    input  logic        cfg_wr,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    csimcb_cmd_t cmd;
    csimcb_sts_t sts;

    // Sequence each transaction; branch on datapath status and wait on the square root.
    csimcb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Hold buffer state, the magnitude store and the result registers.
    csimcb_dp #(
        .MAX_PACKETS (MAX_PACKETS),
        .SUBCARRIERS (SUBCARRIERS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule

// File: design/csimcb_checker.sv
// Port-level checks of the CSI magnitude capture buffer, bound to the top level.
// Depends on csimcb_pkg and csi_magnitude_capture_buffer_top_macros.svh.
`include "csi_magnitude_capture_buffer_top_macros.svh"

module csimcb_checker
    import csimcb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input csimcb_rsp_t rsp
);

    `CSIMCB_ASSERT_SAME(a_done_not_busy, done, !busy, "result strobe while busy")
    `CSIMCB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accept")
    `CSIMCB_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without transaction")
    `CSIMCB_ASSERT_SAME(a_byte_zero, done && (rsp.status != ST_READ_OK), rsp.read_byte == 8'd0, "nonzero byte without read ok")
    `CSIMCB_ASSERT_SAME(a_count_moves_on_done, !$stable(rsp.stored_packets), done, "packet count changed outside a result")

endmodule

bind csi_magnitude_capture_buffer_top csimcb_checker u_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// File: dv/csi_magnitude_capture_buffer_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for csi_magnitude_capture_buffer_top.
// Depends on csimcb_pkg and the top level; an in-bench capture model scores every result.
module csi_magnitude_capture_buffer_top_test;
    import csimcb_pkg::*;

    localparam int SC_PER_PKT   = CSIMCB_SUBCARRIERS;
    localparam int PKT_SLOTS    = CSIMCB_MAX_PACKETS;
    localparam int STORE_DEPTH  = PKT_SLOTS * SC_PER_PKT;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int RANDOM_ITEMS = 700;
    localparam int PHASES       = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RESET_CYCLES = 5;

    // Request codes the block does not define; they must answer done and change nothing.
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    // I/Q corner pairs for the directed samples.
    localparam logic signed [7:0] EDGE_I [6] = '{-8'sd128, 8'sd127, -8'sd128, 8'sd127, 8'sd0, -8'sd1};
    localparam logic signed [7:0] EDGE_Q [6] = '{-8'sd128, 8'sd127, 8'sd127, -8'sd128, 8'sd0, -8'sd1};

    // A pending transaction and the idle cycles to spend before presenting it.
    typedef struct packed {
        logic [3:0]  gap;
        csimcb_req_t r;
    } queued_req_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    csimcb_req_t req_bus   = '0;
    logic        done;
    csimcb_rsp_t rsp;
    logic        cfg_wr    = 1'b0;
    cfg_index_t  cfg_index = CFG_BUFFER_PACKETS;
    logic [10:0] cfg_data  = '0;

    queued_req_t request_backlog [$];
    csimcb_rsp_t expected_capture_rsp [$];

    // Driver state, read by the stimulus process to decide when the block is idle.
    logic        staged     = 1'b0;
    queued_req_t staged_req;
    logic [3:0]  gap_left   = '0;
    logic        req_taken  = 1'b0;
    logic        no_idle    = 1'b0;

    int unsigned failure_count  = 0;
    int unsigned accepted_count = 0;
    int unsigned queued_items   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned setting_count  = 0;
    int unsigned n_stored       = 0;
    int unsigned n_read_ok      = 0;
    int unsigned n_full         = 0;

    // Capture model: store, packet progress and the register copies.
    logic [7:0]  mag_mem [STORE_DEPTH];
    logic [10:0] m_count    = '0;
    logic [6:0]  m_index    = '0;
    logic        m_len_err  = 1'b0;
    logic        m_open     = 1'b0;
    logic        m_has_buf  = 1'b0;
    logic [10:0] m_buf_pkts = BUFFER_PACKETS_RST;
    logic [5:0]  m_guard_lo = GUARD_LOW_RST;
    logic [5:0]  m_guard_hi = GUARD_HIGH_RST;
    logic [5:0]  m_dc       = DC_INDEX_RST;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    csi_magnitude_capture_buffer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req_bus),
        .done      (done),
        .rsp       (rsp),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Floor of the I/Q vector length, found one result bit at a time from the top.
    function automatic logic [7:0] iq_magnitude(logic signed [7:0] i_v, logic signed [7:0] q_v);
        int iv;
        int qv;
        int power;
        int root;
        int trial;
        iv    = int'(i_v);
        qv    = int'(q_v);
        power = iv * iv + qv * qv;
        root  = 0;
        for (int b = 8; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= power)
                root = trial;
        end
        return (root > MAG_MAX) ? MAG_MAX : root[7:0];
    endfunction

    function automatic logic capture_full();
        return m_count >= ((m_buf_pkts < PKT_SLOTS) ? m_buf_pkts : PKT_SLOTS);
    endfunction

    // Advance the capture model by one transaction and return the result it owes.
    function automatic csimcb_rsp_t predict_capture_rsp(csimcb_req_t r);
        csimcb_rsp_t         o;
        int                  sc;
        int                  span;
        logic [STORE_AW-1:0] addr;
        o        = '0;
        o.status = ST_DONE;
        // Any command drops a packet in progress.
        if (r.req_type <= REQ_DISCARD)
        begin
            m_index   = '0;
            m_len_err = 1'b0;
        end
        case (r.req_type)
            REQ_OPEN_WRITE:
                if (m_buf_pkts == 0 || m_buf_pkts > PKT_SLOTS)
                    o.status = ST_OPEN_FAILED;
                else
                begin
                    m_has_buf = 1'b1;
                    m_count   = '0;
                    m_open    = 1'b1;
                end
            REQ_OPEN_READ:
                if (!m_has_buf)
                    o.status = ST_OPEN_FAILED;
                else
                    m_open = 1'b1;
            REQ_CLOSE:
                m_open = 1'b0;
            REQ_DISCARD:
            begin
                m_has_buf = 1'b0;
                m_count   = '0;
            end
            REQ_WRITE_SAMPLE:
            begin
                sc = int'(m_index);
                if (capture_full())
                begin
                    o.status = ST_FULL;
                    n_full++;
                end
                else if (!m_has_buf || !m_open)
                    o.status = ST_NOT_OPEN;
                else
                begin
                    if (sc < SC_PER_PKT)
                    begin
                        addr = STORE_AW'(int'(m_count) * SC_PER_PKT + sc);
                        mag_mem[addr] =
                            (sc < m_guard_lo || sc > m_guard_hi || sc == m_dc) ?
                            8'd0 : iq_magnitude(r.i_sample, r.q_sample);
                        m_index = 7'(sc + 1);
                    end
                    else
                        m_len_err = 1'b1;
                    if (r.last_sample)
                    begin
                        if (!m_len_err && sc == SC_PER_PKT - 1)
                        begin
                            m_count++;
                            o.status = ST_STORED;
                            n_stored++;
                        end
                        else
                            o.status = ST_REJECTED;
                        m_index   = '0;
                        m_len_err = 1'b0;
                    end
                    else
                        o.status = ST_SAMPLE_TAKEN;
                end
            end
            REQ_READ_BYTE:
            begin
                o.status = ST_READ_EMPTY;
                if (m_has_buf && r.start_packet < m_count)
                begin
                    // Clamp the window to the packets committed past its start.
                    span = int'(m_count) - int'(r.start_packet);
                    if (r.window_packets < span)
                        span = int'(r.window_packets);
                    if (r.byte_offset < span * SC_PER_PKT)
                    begin
                        addr = STORE_AW'(int'(r.start_packet) * SC_PER_PKT
                                         + int'(r.byte_offset));
                        o.read_byte = mag_mem[addr];
                        o.status    = ST_READ_OK;
                        n_read_ok++;
                    end
                end
            end
            default: ;
        endcase
        o.is_full_flag   = capture_full();
        o.stored_packets = m_count;
        return o;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failure_count++;
        end
    endfunction

    // Set the request code and fill every other field at random.
    function automatic csimcb_req_t rand_req(logic [2:0] code);
        csimcb_req_t r;
        r                = '0;
        r.req_type       = code;
        r.q_sample       = 8'($urandom);
        r.i_sample       = 8'($urandom);
        r.last_sample    = 1'($urandom);
        r.start_packet   = 10'($urandom);
        r.window_packets = 11'($urandom_range(0, PKT_SLOTS));
        r.byte_offset    = 16'($urandom);
        return r;
    endfunction

    function automatic void push_req(csimcb_req_t r);
        queued_req_t item;
        item.gap = no_idle ? 4'd0 : 4'($urandom_range(0, 10));
        item.r   = r;
        request_backlog.push_back(item);
        queued_items++;
    endfunction

    // Queue len samples; mark the final one last when asked.
    function automatic void queue_packet(int len, logic mark_end);
        csimcb_req_t r;
        for (int k = 0; k < len; k++)
        begin
            r             = rand_req(REQ_WRITE_SAMPLE);
            r.last_sample = mark_end && (k == len - 1);
            if ($urandom_range(0, 15) == 0)
            begin
                r.i_sample = $urandom_range(0, 1) ? -8'sd128 : 8'sd127;
                r.q_sample = $urandom_range(0, 1) ? -8'sd128 : 8'sd127;
            end
            push_req(r);
        end
    endfunction

    // Queue reads aimed mostly inside the packets this phase should have committed.
    function automatic void queue_reads(int n, int pk);
        csimcb_req_t r;
        int          win;
        for (int k = 0; k < n; k++)
        begin
            r = rand_req(REQ_READ_BYTE);
            case ($urandom_range(0, 3))
                0: ;
                1, 2:
                begin
                    r.start_packet   = 10'($urandom_range(0,
                                           (pk > PKT_SLOTS - 1) ? PKT_SLOTS - 1 : pk));
                    win              = $urandom_range(0, pk + 1);
                    r.window_packets = 11'(win);
                    r.byte_offset    = 16'($urandom_range(0, win * SC_PER_PKT + 8));
                end
                default:
                begin
                    r.start_packet   = '0;
                    r.window_packets = 11'(PKT_SLOTS);
                    r.byte_offset    = 16'($urandom_range(0, pk * SC_PER_PKT + 8));
                end
            endcase
            push_req(r);
        end
    endfunction

    // One random phase: open, then mostly whole packets with reads, commands and noise.
    function automatic void queue_phase(int budget);
        int          pk;
        int unsigned base;
        logic [2:0]  code;
        pk      = 0;
        base    = queued_items;
        no_idle = 1'b0;
        push_req(rand_req(REQ_OPEN_WRITE));
        while (queued_items - base < budget)
        begin
            // Run some stretches back to back with no idle cycles.
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    if ($urandom_range(0, 4) != 0)
                    begin
                        queue_packet(SC_PER_PKT, 1'b1);
                        pk++;
                    end
                    else
                        queue_packet($urandom_range(1, SC_PER_PKT + 4), $urandom_range(0, 3) != 0);
                6, 7:
                    queue_reads($urandom_range(2, 8), pk);
                8:
                begin
                    code = 3'($urandom_range(0, 3));
                    push_req(rand_req(code));
                    if (code == REQ_OPEN_WRITE || code == REQ_DISCARD)
                        pk = 0;
                    // Reopen most of the time so later samples get past the open check.
                    if ((code == REQ_CLOSE || code == REQ_DISCARD) && $urandom_range(0, 3) != 0)
                    begin
                        push_req(rand_req((code == REQ_CLOSE && $urandom_range(0, 1)) ?
                                          REQ_OPEN_READ : REQ_OPEN_WRITE));
                        if (code == REQ_DISCARD)
                            pk = 0;
                    end
                end
                default:
                    push_req(rand_req(3'($urandom_range(0, 7))));
            endcase
        end
    endfunction

    // Hold until nothing is queued, staged, presented or awaiting its result.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_backlog.size() != 0 || staged || start || expected_capture_rsp.size() != 0);
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [10:0] val);
        @(negedge clk);
        cfg_wr    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr <= 1'b0;
        case (idx)
            CFG_BUFFER_PACKETS: m_buf_pkts = val;
            CFG_GUARD_LOW:      m_guard_lo = val[5:0];
            CFG_GUARD_HIGH:     m_guard_hi = val[5:0];
            CFG_DC_INDEX:       m_dc       = val[5:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [10:0] pkts, logic [5:0] lo, logic [5:0] hi, logic [5:0] dc);
        write_cfg(CFG_BUFFER_PACKETS, pkts);
        write_cfg(CFG_GUARD_LOW, 11'(lo));
        write_cfg(CFG_GUARD_HIGH, 11'(hi));
        write_cfg(CFG_DC_INDEX, 11'(dc));
        setting_count++;
    endtask

    // Driver: change inputs on the falling edge. Drop start once the transaction is
    // taken, or keep it high straight into the next one when no gap is due.
    always @(negedge clk)
    begin : drive_proc
        logic drive_next;
        drive_next = start;
        if (start && req_taken)
            drive_next = 1'b0;
        if (!staged && request_backlog.size() != 0)
        begin
            staged_req = request_backlog.pop_front();
            gap_left   = staged_req.gap;
            staged     = 1'b1;
        end
        if (rst_n && staged && !drive_next)
        begin
            if (gap_left != 0)
                gap_left--;
            else
            begin
                drive_next = 1'b1;
                req_bus   <= staged_req.r;
                staged     = 1'b0;
            end
        end
        start <= drive_next;
    end

    // Monitor: sample on the rising edge. Score the result shown this cycle against
    // the oldest expectation, then predict any transaction taken at this edge.
    always @(posedge clk)
    begin : score_proc
        csimcb_rsp_t want;
        logic        took;
        took = rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (expected_capture_rsp.size() == 0)
            begin
                $error("result with no transaction outstanding: status %0d", rsp.status);
                failure_count++;
            end
            else
            begin
                want = expected_capture_rsp.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("read_byte", 32'(want.read_byte), 32'(rsp.read_byte));
                check_field("is_full_flag", 32'(want.is_full_flag), 32'(rsp.is_full_flag));
                check_field("stored_packets", 32'(want.stored_packets),
                            32'(rsp.stored_packets));
            end
        end
        if (took)
        begin
            expected_capture_rsp.push_back(predict_capture_rsp(req_bus));
            accepted_count++;
        end
        req_taken <= took;
        // Watchdog: count cycles in which nothing moves on either port.
        if (!rst_n || took || done || cfg_wr)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus_proc
        csimcb_req_t r;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: open every guard so the I/Q corners reach the square root,
        // and put DC inside the short packet.
        apply_setting(BUFFER_PACKETS_RST, 6'd0, 6'd63, 6'd3);
        push_req(rand_req(REQ_WRITE_SAMPLE));   // sample before any open
        push_req(rand_req(REQ_READ_BYTE));      // read without a buffer
        push_req(rand_req(REQ_OPEN_READ));      // open read without a buffer fails
        push_req(rand_req(REQ_UNUSED_6));
        push_req(rand_req(REQ_UNUSED_7));
        push_req(rand_req(REQ_CLOSE));
        push_req(rand_req(REQ_DISCARD));
        push_req(rand_req(REQ_OPEN_WRITE));
        // Short packet with corner I/Q values: rejected on its last sample.
        for (int k = 0; k < 6; k++)
        begin
            r             = rand_req(REQ_WRITE_SAMPLE);
            r.i_sample    = EDGE_I[3'(k)];
            r.q_sample    = EDGE_Q[3'(k)];
            r.last_sample = (k == 5);
            push_req(r);
        end
        r              = rand_req(REQ_READ_BYTE);
        r.start_packet = '0;
        push_req(r);                            // buffer open but nothing stored
        push_req(rand_req(REQ_OPEN_READ));
        push_req(rand_req(REQ_CLOSE));
        push_req(rand_req(REQ_WRITE_SAMPLE));   // closed: not open
        push_req(rand_req(REQ_OPEN_READ));
        r             = rand_req(REQ_WRITE_SAMPLE);
        r.last_sample = 1'b0;
        push_req(r);                            // writing after open read is allowed
        push_req(rand_req(REQ_DISCARD));        // drops the partial packet
        push_req(rand_req(REQ_WRITE_SAMPLE));   // no buffer, still marked open
        r                = rand_req(REQ_READ_BYTE);
        r.start_packet   = '1;
        r.window_packets = 11'(PKT_SLOTS);
        r.byte_offset    = '1;
        push_req(r);
        wait_idle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: apply_setting(11'd1, 6'd0, 6'd63, 6'd0);
                1: apply_setting(11'd2, 6'd63, 6'd0, 6'd63);
                2: apply_setting(BUFFER_PACKETS_RST, GUARD_LOW_RST, GUARD_HIGH_RST, DC_INDEX_RST);
                3: apply_setting(11'($urandom_range(1, 3)), 6'($urandom), 6'($urandom), 6'($urandom));
                4: apply_setting(11'd0, 6'($urandom), 6'($urandom), 6'($urandom));
                5: apply_setting(11'h7ff, 6'd20, 6'd40, 6'd30);
                6: apply_setting(11'd1024, 6'd0, 6'd63, 6'd63);
                default:
                    apply_setting(11'($urandom_range(1, 4)), 6'($urandom_range(0, 20)),
                                  6'($urandom_range(40, 63)), 6'($urandom_range(0, 63)));
            endcase
            queue_phase(RANDOM_ITEMS / PHASES);
            wait_idle();
        end

        // Drain: give a late or spurious result time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_capture_rsp.size() != 0)
        begin
            $error("%0d results never arrived", expected_capture_rsp.size());
            failure_count++;
        end
        $display("Ran %0d transactions under %0d register settings.",
                 accepted_count, setting_count);
        $display("Packets stored %0d, bytes read back %0d, samples refused as full %0d.",
                 n_stored, n_read_ok, n_full);
        if (failure_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
